### rtl/core/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, field widths, command and status codes, and elaboration-time
// helpers for the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    // Payload field widths.
    localparam int CMD_W     = 2;
    localparam int REQ_W     = 16;
    localparam int ADDR_W    = 18;
    localparam int BYTES_W   = 11;
    localparam int STATUS_W  = 3;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes.
    localparam cmd_t CMD_ALLOC = 2'd0;
    localparam cmd_t CMD_FREE  = 2'd1;
    localparam cmd_t CMD_QUERY = 2'd2;

    // Status codes.
    localparam status_t STATUS_OK           = 3'd0;
    localparam status_t STATUS_OUT_OF_PAGES = 3'd1;
    localparam status_t STATUS_TOO_LARGE    = 3'd2;
    localparam status_t STATUS_PAGE_ALIGNED = 3'd3;
    localparam status_t STATUS_NOT_CARVED   = 3'd4;

    // Number of leading chunks covered by the page header. A page with n
    // chunks carries a header of 4 + 4n bytes, rounded up to whole chunks.
    function automatic int header_chunks(int page_shift, int chunk_shift);
        int n;
        n = 1 << (page_shift - chunk_shift);
        return (4 + 4 * n + (1 << chunk_shift) - 1) >> chunk_shift;
    endfunction

    // Chunks per page for a given chunk size.
    function automatic int page_chunks(int page_shift, int chunk_shift);
        return (chunk_shift > page_shift) ? 0 : (1 << (page_shift - chunk_shift));
    endfunction

endpackage

### rtl/core/scsa_ram.sv
// ----------------------------------------------------------------------------
// scsa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/size_class_slab_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator_top
// Small-block allocator with power-of-two size classes, one LIFO free list
// per class, and pages carved on demand into linked chunk lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): command, request size and block address. One
//   transfer is one allocate, free or size query. Result channel (m_*):
//   granted address, chunk size and status, exactly one result per command.
//   The block works on one command at a time. Free, query, error and
//   unknown commands pass through a lookup and a response state; an
//   allocate served from a non-empty list also passes through a pop
//   state. The next command is taken once the block is back in idle
//   after loading its result. An allocate that finds its list empty
//   carves a fresh page first, one link write per cycle through the
//   single write port of the link memory for each chunk after the
//   header chunks, and then reads the successor of the fresh head.
//   The output register holds a result until it is taken. While the
//   receiver stalls, one more command is taken and worked up to its result,
//   and then it waits and no new command is taken.
//   Reset empties all free lists and marks all pages uncarved at once (a
//   fill count of carved pages); the link memory is not cleared and no
//   clearing pass is needed, so commands are taken right after reset.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_top #(
    parameter int PAGE_BYTES  = 4096,
    parameter int NUM_CLASSES = 6,
    parameter int MIN_SHIFT   = 5,
    parameter int NUM_PAGES   = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [scsa_pkg::CMD_W-1:0]        s_command,
    input  logic [scsa_pkg::REQ_W-1:0]        s_request_bytes,
    input  logic [scsa_pkg::ADDR_W-1:0]       s_block_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [scsa_pkg::ADDR_W-1:0]       m_granted_address,
    output logic [scsa_pkg::BYTES_W-1:0]      m_chunk_bytes,
    output logic [scsa_pkg::STATUS_W-1:0]     m_status
);

    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int PAGE_IDX_SHIFT = PAGE_SHIFT - MIN_SHIFT;
    localparam int LINK_DEPTH     = NUM_PAGES * (PAGE_BYTES >> MIN_SHIFT);
    localparam int IDX_W          = $clog2(LINK_DEPTH);
    localparam int LINK_W         = IDX_W + 1;
    localparam int PG_AW          = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int PU_W           = $clog2(NUM_PAGES + 1);
    localparam int CLS_W          = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int LARGEST_CLASS  = 1 << (MIN_SHIFT + NUM_CLASSES - 1);
    localparam int ALLOC_MAX      = ((PAGE_BYTES / 4) < LARGEST_CLASS) ?
                                    (PAGE_BYTES / 4) : LARGEST_CLASS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CARVE,
        ST_HEAD_RD,
        ST_POP,
        ST_RESP
    } state_t;

    // Control state.
    state_t                          state_reg, state_next;
    logic                            m_valid_reg, m_valid_next;
    logic [scsa_pkg::ADDR_W-1:0]     m_granted_address_reg, m_granted_address_next;
    logic [scsa_pkg::BYTES_W-1:0]    m_chunk_bytes_reg, m_chunk_bytes_next;
    scsa_pkg::status_t               m_status_reg, m_status_next;
    logic [PU_W-1:0]                 pages_used_reg, pages_used_next;
    logic [NUM_CLASSES-1:0]          head_valid_reg, head_valid_next;

    // Payload state.
    scsa_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [scsa_pkg::ADDR_W-1:0]     addr_reg, addr_next;
    logic [CLS_W-1:0]                cls_reg, cls_next;
    logic                            too_large_reg, too_large_next;
    logic [IDX_W-1:0]                head_idx_reg [NUM_CLASSES];
    logic [IDX_W-1:0]                head_idx_next [NUM_CLASSES];
    logic [IDX_W-1:0]                carve_ptr_reg, carve_ptr_next;
    logic [IDX_W-1:0]                carve_last_reg, carve_last_next;
    logic [scsa_pkg::ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [scsa_pkg::BYTES_W-1:0]    res_bytes_reg, res_bytes_next;
    scsa_pkg::status_t               res_status_reg, res_status_next;

    // Memory ports.
    logic                            link_we;
    logic [IDX_W-1:0]                link_waddr;
    logic [LINK_W-1:0]               link_wdata;
    logic [IDX_W-1:0]                link_raddr;
    logic [LINK_W-1:0]               link_rdata;
    logic                            pc_we;
    logic [PG_AW-1:0]                pc_waddr;
    logic [CLS_W-1:0]                pc_wdata;
    logic [PG_AW-1:0]                pc_raddr;
    logic [CLS_W-1:0]                pc_rdata;

    // Per-class carve constants, offsets in link-index units within a page.
    logic [IDX_W-1:0]                first_off [NUM_CLASSES];
    logic [IDX_W-1:0]                last_off  [NUM_CLASSES];
    logic [NUM_CLASSES-1:0]          class_empty;

    // Request decode and datapath helpers.
    logic [CLS_W-1:0]                req_cls;
    logic                            req_too_large;
    logic [31:0]                     page_in;
    logic [31:0]                     page_num;
    logic                            page_aligned;
    logic                            page_carved;
    logic                            out_of_pages;
    logic [31:0]                     free_idx_full;
    logic [IDX_W-1:0]                free_idx;
    logic [31:0]                     free_bytes_full;
    logic [31:0]                     alloc_bytes_full;
    logic [31:0]                     base_idx_full;
    logic [IDX_W-1:0]                base_idx;
    logic [31:0]                     step_full;
    logic [IDX_W-1:0]                carve_step;
    logic [IDX_W-1:0]                ptr_adv;
    logic [IDX_W-1:0]                head_idx_cur;
    logic                            head_valid_cur;
    logic [31:0]                     grant_full;

    // Link memory: next-chunk pointer with a valid bit for every chunk.
    scsa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (link_raddr),
        .rd_data (link_rdata)
    );

    // Page class memory: class of each carved page, valid below pages_used.
    scsa_ram #(
        .WIDTH (CLS_W),
        .DEPTH (NUM_PAGES)
    ) u_page_ram (
        .aclk    (aclk),
        .wr_en   (pc_we),
        .wr_addr (pc_waddr),
        .wr_data (pc_wdata),
        .rd_addr (pc_raddr),
        .rd_data (pc_rdata)
    );

    // Header skip and last chunk of a page, fixed per class.
    for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_class
        localparam int CS   = MIN_SHIFT + k;
        localparam int NCH  = scsa_pkg::page_chunks(PAGE_SHIFT, CS);
        localparam int SKIP = scsa_pkg::header_chunks(PAGE_SHIFT, CS);
        localparam int LAST = (NCH > 0) ? ((NCH - 1) << k) : 0;
        assign first_off[k]   = IDX_W'(SKIP << k);
        assign last_off[k]    = IDX_W'(LAST);
        assign class_empty[k] = (SKIP >= NCH);
    end

    // Size class of the incoming request: smallest class that holds it.
    always_comb begin
        req_too_large = (32'(s_request_bytes) > ALLOC_MAX);
        req_cls       = '0;
        for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            if (32'(s_request_bytes) <= (32'd1 << (MIN_SHIFT + k))) begin
                req_cls = CLS_W'(k);
            end
        end
    end

    // The page class read is started by the address of the incoming transfer.
    assign page_in  = 32'(s_block_address >> PAGE_SHIFT);
    assign pc_raddr = page_in[PG_AW-1:0];

    // Free and query checks on the held address.
    assign page_num     = 32'(addr_reg >> PAGE_SHIFT);
    assign page_aligned = (addr_reg[PAGE_SHIFT-1:0] == '0);
    assign page_carved  = (page_num < 32'(pages_used_reg));

    // Chunk index of a freed block, rounded down to its chunk boundary.
    assign free_idx_full   = 32'(addr_reg >> MIN_SHIFT) & ~((32'd1 << pc_rdata) - 32'd1);
    assign free_idx        = free_idx_full[IDX_W-1:0];
    assign free_bytes_full = 32'd1 << (MIN_SHIFT + int'(pc_rdata));

    // Allocation datapath for the held class.
    assign alloc_bytes_full = 32'd1 << (MIN_SHIFT + int'(cls_reg));
    assign out_of_pages     = (32'(pages_used_reg) >= NUM_PAGES);
    assign base_idx_full    = 32'(pages_used_reg) << PAGE_IDX_SHIFT;
    assign base_idx         = base_idx_full[IDX_W-1:0];
    assign step_full        = 32'd1 << cls_reg;
    assign carve_step       = step_full[IDX_W-1:0];
    assign ptr_adv          = carve_ptr_reg + carve_step;
    assign head_idx_cur     = head_idx_reg[cls_reg];
    assign head_valid_cur   = head_valid_reg[cls_reg];
    assign grant_full       = 32'(head_idx_cur) << MIN_SHIFT;

    // The link read always fetches the successor of the current head.
    assign link_raddr = head_idx_cur;

    // Command sequencer.
    always_comb begin
        state_next             = state_reg;
        m_valid_next           = m_valid_reg;
        m_granted_address_next = m_granted_address_reg;
        m_chunk_bytes_next     = m_chunk_bytes_reg;
        m_status_next          = m_status_reg;
        pages_used_next        = pages_used_reg;
        head_valid_next        = head_valid_reg;
        head_idx_next          = head_idx_reg;
        cmd_next               = cmd_reg;
        addr_next              = addr_reg;
        cls_next               = cls_reg;
        too_large_next         = too_large_reg;
        carve_ptr_next         = carve_ptr_reg;
        carve_last_next        = carve_last_reg;
        res_addr_next          = res_addr_reg;
        res_bytes_next         = res_bytes_reg;
        res_status_next        = res_status_reg;
        link_we                = 1'b0;
        link_waddr             = carve_ptr_reg;
        link_wdata             = '0;
        pc_we                  = 1'b0;
        pc_waddr               = pages_used_reg[PG_AW-1:0];
        pc_wdata               = cls_reg;

        // A taken result frees the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next       = s_command;
                    addr_next      = s_block_address;
                    cls_next       = req_cls;
                    too_large_next = req_too_large;
                    state_next     = ST_LOOKUP;
                end
            end

            ST_LOOKUP: begin
                res_addr_next   = '0;
                res_bytes_next  = '0;
                res_status_next = scsa_pkg::STATUS_OK;
                state_next      = ST_RESP;
                unique case (cmd_reg) inside
                    scsa_pkg::CMD_ALLOC: begin
                        if (too_large_reg) begin
                            res_status_next = scsa_pkg::STATUS_TOO_LARGE;
                        end else if (head_valid_cur) begin
                            // Successor read was issued this cycle.
                            state_next = ST_POP;
                        end else if (out_of_pages) begin
                            res_status_next = scsa_pkg::STATUS_OUT_OF_PAGES;
                        end else begin
                            // Claim the next page for this class.
                            pc_we           = 1'b1;
                            pages_used_next = pages_used_reg + PU_W'(1);
                            if (class_empty[cls_reg]) begin
                                res_status_next = scsa_pkg::STATUS_OUT_OF_PAGES;
                            end else begin
                                head_valid_next[cls_reg] = 1'b1;
                                head_idx_next[cls_reg]   = base_idx + first_off[cls_reg];
                                carve_ptr_next           = base_idx + first_off[cls_reg];
                                carve_last_next          = base_idx + last_off[cls_reg];
                                state_next               = ST_CARVE;
                            end
                        end
                    end
                    scsa_pkg::CMD_FREE, scsa_pkg::CMD_QUERY: begin
                        if (page_aligned) begin
                            res_status_next = scsa_pkg::STATUS_PAGE_ALIGNED;
                        end else if (!page_carved) begin
                            res_status_next = scsa_pkg::STATUS_NOT_CARVED;
                        end else if (cmd_reg == scsa_pkg::CMD_QUERY) begin
                            res_bytes_next = free_bytes_full[scsa_pkg::BYTES_W-1:0];
                        end else begin
                            // Push the chunk onto its class list.
                            link_we                   = 1'b1;
                            link_waddr                = free_idx;
                            link_wdata                = {head_valid_reg[pc_rdata],
                                                         head_idx_reg[pc_rdata]};
                            head_valid_next[pc_rdata] = 1'b1;
                            head_idx_next[pc_rdata]   = free_idx;
                        end
                    end
                    default: begin
                        // Unknown command: all-zero result, no state change.
                    end
                endcase
            end

            ST_CARVE: begin
                // Link one chunk per cycle; the last chunk ends the list.
                link_we        = 1'b1;
                link_waddr     = carve_ptr_reg;
                carve_ptr_next = ptr_adv;
                if (carve_ptr_reg == carve_last_reg) begin
                    link_wdata = '0;
                    state_next = ST_HEAD_RD;
                end else begin
                    link_wdata = {1'b1, ptr_adv};
                end
            end

            ST_HEAD_RD: begin
                // Successor read of the fresh head is issued here.
                state_next = ST_POP;
            end

            ST_POP: begin
                head_valid_next[cls_reg] = link_rdata[IDX_W];
                head_idx_next[cls_reg]   = link_rdata[IDX_W-1:0];
                res_addr_next            = grant_full[scsa_pkg::ADDR_W-1:0];
                res_bytes_next           = alloc_bytes_full[scsa_pkg::BYTES_W-1:0];
                res_status_next          = scsa_pkg::STATUS_OK;
                state_next               = ST_RESP;
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_granted_address_next = res_addr_reg;
                    m_chunk_bytes_next     = res_bytes_reg;
                    m_status_next          = res_status_reg;
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, list heads, page count and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            m_valid_reg           <= 1'b0;
            m_granted_address_reg <= '0;
            m_chunk_bytes_reg     <= '0;
            m_status_reg          <= scsa_pkg::STATUS_OK;
            pages_used_reg        <= '0;
            head_valid_reg        <= '0;
        end else begin
            state_reg             <= state_next;
            m_valid_reg           <= m_valid_next;
            m_granted_address_reg <= m_granted_address_next;
            m_chunk_bytes_reg     <= m_chunk_bytes_next;
            m_status_reg          <= m_status_next;
            pages_used_reg        <= pages_used_next;
            head_valid_reg        <= head_valid_next;
        end
    end

    // Held command, head pointers, carve walk and pending result.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        addr_reg       <= addr_next;
        cls_reg        <= cls_next;
        too_large_reg  <= too_large_next;
        head_idx_reg   <= head_idx_next;
        carve_ptr_reg  <= carve_ptr_next;
        carve_last_reg <= carve_last_next;
        res_addr_reg   <= res_addr_next;
        res_bytes_reg  <= res_bytes_next;
        res_status_reg <= res_status_next;
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_granted_address = m_granted_address_reg;
    assign m_chunk_bytes     = m_chunk_bytes_reg;
    assign m_status          = m_status_reg;

endmodule

### rtl/core/scsa_checker.sv
// ----------------------------------------------------------------------------
// scsa_checker
// Port-level checks for the size-class slab allocator, bound to the top.
// ----------------------------------------------------------------------------
module scsa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [scsa_pkg::CMD_W-1:0]    s_command,
    input logic [scsa_pkg::REQ_W-1:0]    s_request_bytes,
    input logic [scsa_pkg::ADDR_W-1:0]   s_block_address,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [scsa_pkg::ADDR_W-1:0]   m_granted_address,
    input logic [scsa_pkg::BYTES_W-1:0]  m_chunk_bytes,
    input logic [scsa_pkg::STATUS_W-1:0] m_status
);

    // A stalled result holds its contents.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_granted_address) &&
                                $stable(m_chunk_bytes) && $stable(m_status))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Commands are handled one at a time: no transfer right after another.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a command is in progress");

    // A failed command reports neither an address nor a size.
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != scsa_pkg::STATUS_OK) |->
            (m_granted_address == '0) && (m_chunk_bytes == '0))
        else $error("error result carries data");

    // A granted chunk is aligned to its own size.
    a_grant_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_granted_address != '0) |->
            (m_chunk_bytes != '0) &&
            ((m_granted_address & scsa_pkg::ADDR_W'(m_chunk_bytes - 1'b1)) == '0))
        else $error("granted address not chunk aligned");

endmodule

bind size_class_slab_allocator_top scsa_checker u_scsa_checker (.*);
